// ===== design/bme_pkg.sv =====
// Shared constants and types for the bicycle model Euler step core.
// Used by bme_sincos and by the top level; depends on nothing else.
`default_nettype none
package bme_pkg;

  // Fixed-point constants in Q2.30.
  localparam logic [30:0]        Q30_ONE      = 31'd1073741824;
  localparam logic signed [35:0] TWO_PI_Q30   = 36'sd6746518852;
  localparam logic [32:0]        TWO_PI_U     = 33'd6746518852;
  localparam logic [34:0]        HALF_PI_X1   = 35'd1686629713;
  localparam logic [34:0]        HALF_PI_X2   = 35'd3373259426;
  localparam logic [34:0]        HALF_PI_X3   = 35'd5059889139;
  localparam logic [34:0]        HALF_PI_X4   = 35'd6746518852;

  // Quadrant thresholds: j*pi/2 - pi/4 for j = 1..4.
  localparam logic [32:0] QUAD_TH1 = 33'd843314857;
  localparam logic [32:0] QUAD_TH2 = 33'd2529944570;
  localparam logic [32:0] QUAD_TH3 = 33'd4216574283;
  localparam logic [32:0] QUAD_TH4 = 33'd5903203996;

  // floor(2^62 / (2*pi in Q2.30)), used to estimate the turn count.
  localparam logic [29:0] HEAD_RECIP = 30'((64'd1 << 62) / 64'd6746518852);

  localparam logic [30:0]        WHEELBASE_MIN   = 31'd655;
  localparam logic [30:0]        WHEELBASE_RESET = 31'd13107;
  localparam logic [16:0]        TIME_STEP_RESET = 17'd655;
  localparam logic signed [17:0] STEER_LIMIT     = 18'sd65536;

  typedef enum logic [0:0] {
    REG_WHEELBASE = 1'b0,
    REG_TIME_STEP = 1'b1
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== design/bme_sincos.sv =====
// Pipelined sine and cosine of a Q2.30 angle by Horner-form Taylor series.
// Thirteen register stages; depends on bme_pkg.
`default_nettype none
module bme_sincos (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] t,
  output logic signed [31:0] s,
  output logic signed [31:0] c
);
  import bme_pkg::*;

  localparam logic [7:0] SIN_DEN [5] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam int         SIN_LG  [5] = '{7, 7, 6, 5, 3};
  localparam logic [7:0] COS_DEN [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam int         COS_LG  [6] = '{8, 7, 6, 5, 4, 1};

  logic signed [31:0] tp  [0:6];
  logic [30:0]        t2p [0:6];
  logic [30:0]        pc  [0:6];
  logic [30:0]        ps  [0:5];
  logic signed [31:0] ta  [0:5];
  logic [30:0]        t2a [0:5];
  logic [30:0]        ac  [0:5];
  logic [30:0]        as_ [0:4];
  logic signed [31:0] sf;
  logic signed [31:0] sout;

  logic signed [63:0] tsq;
  logic signed [63:0] sprod;
  logic signed [63:0] sadj;

  assign tsq   = 64'(t) * 64'(t);
  assign sprod = 64'(tp[5]) * $signed({33'd0, ps[5]});

  always_ff @(posedge clk) begin
    if (en) begin
      tp[0]  <= t;
      t2p[0] <= tsq[60:30];
      pc[0]  <= Q30_ONE;
      ps[0]  <= Q30_ONE;
    end
  end

  // Product of the angle and the sine polynomial, truncated toward zero.
  always_comb begin
    sadj = sprod + ((tp[5] < 0) ? 64'sd1073741823 : 64'sd0);
    if (tp[5] >= 0) begin
      sadj = sprod;
    end
  end

  generate
    for (genvar j = 0; j < 6; j++) begin : g_step
      localparam logic [63:0] CM =
        ((64'd1 << (31 + COS_LG[j])) + 64'(COS_DEN[j]) - 64'd1) / 64'(COS_DEN[j]);
      logic [61:0] cprod_a;
      logic [62:0] cprod_b;
      assign cprod_a = 62'(t2p[j]) * 62'(pc[j]);
      assign cprod_b = 63'(ac[j]) * 63'(CM[31:0]);

      always_ff @(posedge clk) begin
        if (en) begin
          ta[j]    <= tp[j];
          t2a[j]   <= t2p[j];
          ac[j]    <= cprod_a[60:30];
          tp[j+1]  <= ta[j];
          t2p[j+1] <= t2a[j];
          pc[j+1]  <= Q30_ONE - 31'(cprod_b >> (31 + COS_LG[j]));
        end
      end

      if (j < 5) begin : g_sin
        localparam logic [63:0] SM =
          ((64'd1 << (31 + SIN_LG[j])) + 64'(SIN_DEN[j]) - 64'd1) / 64'(SIN_DEN[j]);
        logic [61:0] sprod_a;
        logic [62:0] sprod_b;
        assign sprod_a = 62'(t2p[j]) * 62'(ps[j]);
        assign sprod_b = 63'(as_[j]) * 63'(SM[31:0]);
        always_ff @(posedge clk) begin
          if (en) begin
            as_[j]  <= sprod_a[60:30];
            ps[j+1] <= Q30_ONE - 31'(sprod_b >> (31 + SIN_LG[j]));
          end
        end
      end else begin : g_sin_last
        always_ff @(posedge clk) begin
          if (en) begin
            sf   <= sadj[61:30];
            sout <= sf;
          end
        end
      end
    end
  endgenerate

  assign s = sout;
  assign c = $signed({1'b0, pc[6]});

endmodule
`default_nettype wire

// ===== design/bicycle_model_euler_step_core.sv =====
// One forward-Euler step of a kinematic bicycle model, fully pipelined.
// Depends on bme_pkg and bme_sincos.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_stall | pos_x pos_y heading progress speed
//          |                     | steer_angle path_speed
//  out     | out_valid/out_stall | next_x next_y next_heading next_progress
//  config  | APB write/read      | wheelbase (0x0), time_step (0x4)
//
// One transaction enters per cycle while in_stall is low.
// The latency is set by the two Taylor series pipelines and the two radix-4
// dividers (tangent quotient and division by the wheelbase).
// Reset is synchronous, clears the valid bits and loads the two registers with their reset values.
// A stalled valid output freezes the whole pipeline, so nothing is lost or repeated.
`default_nettype none
module bicycle_model_euler_step_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] heading,
  input  logic signed [31:0] progress,
  input  logic [16:0]        speed,
  input  logic signed [17:0] steer_angle,
  input  logic [16:0]        path_speed,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] next_x,
  output logic signed [31:0] next_y,
  output logic signed [31:0] next_heading,
  output logic signed [31:0] next_progress
);
  import bme_pkg::*;

  localparam int LAT = 49;

  function automatic logic [31:0] sat32(logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Returns {sign, |v|/4}; the quotient is truncated toward zero.
  function automatic logic [29:0] quarter(logic signed [31:0] v);
    logic [32:0] a;
    a = (v < 0) ? 33'(-34'(v)) : 33'(v);
    return {v[31], a[30:2]};
  endfunction

  // Configuration registers.
  logic [30:0] wheelbase;
  logic [16:0] time_step;
  logic [30:0] wbe;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheelbase <= WHEELBASE_RESET;
      time_step <= TIME_STEP_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_WHEELBASE: wheelbase <= pwdata[30:0];
        REG_TIME_STEP: time_step <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_WHEELBASE: prdata = {1'b0, wheelbase};
      REG_TIME_STEP: prdata = {15'd0, time_step};
      default:       prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;
  assign wbe    = (wheelbase < WHEELBASE_MIN) ? WHEELBASE_MIN : wheelbase;

  // Pipeline control.
  logic [LAT:1] vld;
  logic         en;

  assign en        = ~(vld[LAT] & out_stall);
  assign in_stall  = ~en;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // Datapath registers.
  logic [33:0]        vs   [1:34];
  logic signed [31:0] hdd  [1:48];
  logic signed [31:0] pxd  [1:19];
  logic signed [31:0] pyd  [1:19];
  logic signed [31:0] pg1;
  logic [17:0]        dp1;
  logic [31:0]        npd  [2:48];
  logic [31:0]        nxd  [20:48];
  logic [31:0]        nyd  [20:48];
  logic signed [31:0] tst  [1:4];
  logic [1:0]         quad [4:17];
  logic signed [63:0] hm1;
  logic signed [47:0] qx2;
  logic [32:0]        m3;
  logic signed [31:0] t4;
  logic [29:0]        hqc;
  logic [29:0]        hqs;
  logic [62:0]        prx;
  logic [62:0]        pry;
  logic               sgx;
  logic               sgy;

  logic [30:0] tr  [0:16];
  logic [31:0] tl  [0:16];
  logic [31:0] tq  [0:16];
  logic [30:0] td  [0:16];
  logic        tsg [0:16];
  logic [30:0] dr  [0:13];
  logic [25:0] dl  [0:13];
  logic [25:0] dq  [0:13];
  logic        dsg [0:13];

  // Stage one combinational terms.
  logic signed [17:0] st_c;
  logic [33:0]        dpp;
  logic signed [63:0] hm_c;

  always_comb begin
    st_c = steer_angle;
    if (steer_angle > STEER_LIMIT) begin
      st_c = STEER_LIMIT;
    end else if (steer_angle < -STEER_LIMIT) begin
      st_c = -STEER_LIMIT;
    end
  end

  assign dpp  = 34'(time_step) * 34'(path_speed);
  assign hm_c = 64'(heading) * $signed({34'd0, HEAD_RECIP});

  // Heading reduction to [0, 2*pi) and folding into a quadrant.
  logic signed [51:0] qx_c;
  logic signed [47:0] m0_c;
  logic [32:0]        m_c;
  logic [2:0]         k_c;
  logic [34:0]        kh_c;
  logic [34:0]        t_c;

  assign qx_c = 52'($signed(hm1[63:48])) * 52'(TWO_PI_Q30);

  always_comb begin
    m0_c = (48'(hdd[2]) <<< 14) - qx2;
    if (m0_c < 0) begin
      m0_c = m0_c + 48'(TWO_PI_Q30);
    end else if (m0_c >= 48'(TWO_PI_Q30)) begin
      m0_c = m0_c - 48'(TWO_PI_Q30);
    end
    m_c = m0_c[32:0];
  end

  always_comb begin
    k_c = 3'(m3 >= QUAD_TH1) + 3'(m3 >= QUAD_TH2) + 3'(m3 >= QUAD_TH3)
        + 3'(m3 >= QUAD_TH4);
    case (k_c)
      3'd1:    kh_c = HALF_PI_X1;
      3'd2:    kh_c = HALF_PI_X2;
      3'd3:    kh_c = HALF_PI_X3;
      3'd4:    kh_c = HALF_PI_X4;
      default: kh_c = 35'd0;
    endcase
    t_c = {2'b00, m3} - kh_c;
  end

  // Sine and cosine of the folded heading and of the steering angle.
  logic signed [31:0] hs17;
  logic signed [31:0] hc17;
  logic signed [31:0] ss17;
  logic signed [31:0] cs17;

  bme_sincos u_head_sc (
    .clk (clk),
    .en  (en),
    .t   (t4),
    .s   (hs17),
    .c   (hc17)
  );

  bme_sincos u_steer_sc (
    .clk (clk),
    .en  (en),
    .t   (tst[4]),
    .s   (ss17),
    .c   (cs17)
  );

  logic signed [31:0] hsin_c;
  logic signed [31:0] hcos_c;
  logic [30:0]        snum_c;

  always_comb begin
    case (quad[17])
      2'd0:    begin hsin_c = hs17;  hcos_c = hc17;  end
      2'd1:    begin hsin_c = hc17;  hcos_c = -hs17; end
      2'd2:    begin hsin_c = -hs17; hcos_c = -hc17; end
      default: begin hsin_c = -hc17; hcos_c = hs17;  end
    endcase
    snum_c = (ss17 < 0) ? 31'(-33'(ss17)) : 31'(ss17);
  end

  logic signed [34:0] dx_c;
  logic signed [34:0] dy_c;

  always_comb begin
    dx_c = $signed({16'd0, prx[62:44]});
    dy_c = $signed({16'd0, pry[62:44]});
    if (sgx) begin
      dx_c = -dx_c;
    end
    if (sgy) begin
      dy_c = -dy_c;
    end
  end

  // Radix-4 restoring dividers: tangent quotient and the wheelbase division.
  logic [30:0] trn [1:16];
  logic [31:0] tln [1:16];
  logic [31:0] tqn [1:16];
  logic [30:0] drn [1:13];
  logic [25:0] dln [1:13];
  logic [25:0] dqn [1:13];

  always_comb begin
    logic [31:0] r1x;
    logic [31:0] r2x;
    logic [30:0] r1;
    logic        g1;
    logic        g2;
    for (int i = 1; i <= 16; i++) begin
      r1x    = {tr[i-1], tl[i-1][31]};
      g1     = r1x >= {1'b0, td[i-1]};
      r1     = g1 ? 31'(r1x - {1'b0, td[i-1]}) : r1x[30:0];
      r2x    = {r1, tl[i-1][30]};
      g2     = r2x >= {1'b0, td[i-1]};
      trn[i] = g2 ? 31'(r2x - {1'b0, td[i-1]}) : r2x[30:0];
      tln[i] = {tl[i-1][29:0], 2'b00};
      tqn[i] = {tq[i-1][29:0], g1, g2};
    end
    for (int i = 1; i <= 13; i++) begin
      r1x    = {dr[i-1], dl[i-1][25]};
      g1     = r1x >= {1'b0, wbe};
      r1     = g1 ? 31'(r1x - {1'b0, wbe}) : r1x[30:0];
      r2x    = {r1, dl[i-1][24]};
      g2     = r2x >= {1'b0, wbe};
      drn[i] = g2 ? 31'(r2x - {1'b0, wbe}) : r2x[30:0];
      dln[i] = {dl[i-1][23:0], 2'b00};
      dqn[i] = {dq[i-1][23:0], g1, g2};
    end
  end

  logic [63:0]        xprod_c;
  logic signed [34:0] dh_c;

  assign xprod_c = 64'(vs[34]) * 64'(tq[16][31:2]);

  always_comb begin
    dh_c = $signed({9'd0, dq[13]});
    if (dsg[13]) begin
      dh_c = -dh_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: operand capture, products and steering clamp.
      vs[1]  <= 34'(time_step) * 34'(speed);
      hdd[1] <= heading;
      pxd[1] <= pos_x;
      pyd[1] <= pos_y;
      pg1    <= progress;
      dp1    <= dpp[33:16];
      tst[1] <= 32'(st_c) <<< 14;
      hm1    <= hm_c;
      for (int i = 2; i <= 34; i++) vs[i] <= vs[i-1];
      for (int i = 2; i <= 48; i++) hdd[i] <= hdd[i-1];
      for (int i = 2; i <= 19; i++) begin
        pxd[i] <= pxd[i-1];
        pyd[i] <= pyd[i-1];
      end
      for (int i = 2; i <= 4; i++) tst[i] <= tst[i-1];

      // Stages 2 to 4: progress update and heading reduction.
      npd[2] <= sat32(35'(pg1) + $signed({17'd0, dp1}));
      for (int i = 3; i <= 48; i++) npd[i] <= npd[i-1];
      qx2     <= qx_c[47:0];
      m3      <= m_c;
      t4      <= t_c[31:0];
      quad[4] <= k_c[1:0];
      for (int i = 5; i <= 17; i++) quad[i] <= quad[i-1];

      // Stage 18: quadrant mapping and divider setup.
      hqc    <= quarter(hcos_c);
      hqs    <= quarter(hsin_c);
      tr[0]  <= {2'b00, snum_c[30:2]};
      tl[0]  <= {snum_c[1:0], 30'd0};
      tq[0]  <= 32'd0;
      td[0]  <= cs17[30:0];
      tsg[0] <= ss17[31];

      // Stages 19 and 20: position updates.
      prx     <= 63'(vs[18]) * 63'(hqc[28:0]);
      pry     <= 63'(vs[18]) * 63'(hqs[28:0]);
      sgx     <= hqc[29];
      sgy     <= hqs[29];
      nxd[20] <= sat32(35'(pxd[19]) + dx_c);
      nyd[20] <= sat32(35'(pyd[19]) + dy_c);
      for (int i = 21; i <= 48; i++) begin
        nxd[i] <= nxd[i-1];
        nyd[i] <= nyd[i-1];
      end

      // Stages 19 to 34: tangent quotient.
      for (int i = 1; i <= 16; i++) begin
        tr[i]  <= trn[i];
        tl[i]  <= tln[i];
        tq[i]  <= tqn[i];
        td[i]  <= td[i-1];
        tsg[i] <= tsg[i-1];
      end

      // Stage 35: heading rate product, already scaled down by 2^28.
      dr[0]  <= {21'd0, xprod_c[63:54]};
      dl[0]  <= xprod_c[53:28];
      dq[0]  <= 26'd0;
      dsg[0] <= tsg[16];

      // Stages 36 to 48: division by the wheelbase.
      for (int i = 1; i <= 13; i++) begin
        dr[i]  <= drn[i];
        dl[i]  <= dln[i];
        dq[i]  <= dqn[i];
        dsg[i] <= dsg[i-1];
      end

      // Stage 49: output register.
      next_x        <= nxd[48];
      next_y        <= nyd[48];
      next_progress <= npd[48];
      next_heading  <= sat32(35'(hdd[48]) + dh_c);
    end
  end

endmodule
`default_nettype wire

// ===== verif/bme_step_checker.sv =====
// Checker for the bicycle model Euler step core: watches both channels,
// predicts each next state in fixed point and compares it. Depends on nothing.
`timescale 1ns / 100ps
module bme_step_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic [30:0]        wheelbase_cfg,
  input  logic [16:0]        time_step_cfg,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] heading,
  input  logic signed [31:0] progress,
  input  logic [16:0]        speed,
  input  logic signed [17:0] steer_angle,
  input  logic [16:0]        path_speed,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] next_x,
  input  logic signed [31:0] next_y,
  input  logic signed [31:0] next_heading,
  input  logic signed [31:0] next_progress,
  output int                 fail_count,
  output int                 pending,
  output int                 checked
);

  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint QUARTER_PI = 64'sd843314856;
  localparam longint TWO_PI = 64'sd6746518852;

  typedef struct packed {
    logic signed [31:0] x, y, hd, pg;
  } next_state_t;

  next_state_t next_state_q[$];

  function automatic longint fx_mul(longint a, longint b);
    return (a * b) / ONE_Q30;
  endfunction

  function automatic void taylor_sin_cos(input longint t, output longint s, output longint c);
    longint t2, p;
    t2 = fx_mul(t, t);
    p = ONE_Q30;
    p = ONE_Q30 - fx_mul(t2, p) / 110;
    p = ONE_Q30 - fx_mul(t2, p) / 72;
    p = ONE_Q30 - fx_mul(t2, p) / 42;
    p = ONE_Q30 - fx_mul(t2, p) / 20;
    p = ONE_Q30 - fx_mul(t2, p) / 6;
    s = fx_mul(t, p);
    p = ONE_Q30;
    p = ONE_Q30 - fx_mul(t2, p) / 132;
    p = ONE_Q30 - fx_mul(t2, p) / 90;
    p = ONE_Q30 - fx_mul(t2, p) / 56;
    p = ONE_Q30 - fx_mul(t2, p) / 30;
    p = ONE_Q30 - fx_mul(t2, p) / 12;
    p = ONE_Q30 - fx_mul(t2, p) / 2;
    c = p;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic next_state_t euler_step(
    longint px, longint py, longint hd, longint pg,
    longint sp, longint st, longint ps, longint ts, longint wb);
    longint m, q, t, ss, cs, sh, ch, ps_t, pc_t, tn, vstep;
    next_state_t r;
    if (wb < 655) wb = 655;
    if (st > 65536) st = 65536;
    if (st < -65536) st = -65536;
    m = (hd * 16384) % TWO_PI;
    if (m < 0) m += TWO_PI;
    q = (m + QUARTER_PI) / HALF_PI;
    t = m - q * HALF_PI;
    taylor_sin_cos(t, ps_t, pc_t);
    case (q & 3)
      0: begin sh = ps_t; ch = pc_t; end
      1: begin sh = pc_t; ch = -ps_t; end
      2: begin sh = -ps_t; ch = -pc_t; end
      default: begin sh = -pc_t; ch = ps_t; end
    endcase
    taylor_sin_cos(st * 16384, ss, cs);
    tn = (ss * ONE_Q30) / cs;
    vstep = ts * sp;
    r.x = clamp32(px + (vstep * (ch / 4)) / (64'sd1 << 44));
    r.y = clamp32(py + (vstep * (sh / 4)) / (64'sd1 << 44));
    r.hd = clamp32(hd + ((vstep * (tn / 4)) / wb) / (64'sd1 << 28));
    r.pg = clamp32(pg + (ts * ps) / (64'sd1 << 16));
    return r;
  endfunction

  always @(posedge clk) begin
    next_state_t e;
    if (rst) begin
      fail_count <= 0;
      checked <= 0;
      next_state_q.delete();
    end else begin
      if (in_valid && !in_stall)
        next_state_q = {next_state_q, euler_step(pos_x, pos_y, heading, progress, speed,
          steer_angle, path_speed, time_step_cfg, wheelbase_cfg)};
      if (out_valid && !out_stall) begin
        checked <= checked + 1;
        if (next_state_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = next_state_q.pop_front();
          if (e.x !== next_x || e.y !== next_y || e.hd !== next_heading ||
              e.pg !== next_progress) begin
            if (fail_count < 10)
              $display("ERROR: expected x=%0d y=%0d h=%0d p=%0d, got %0d %0d %0d %0d",
                e.x, e.y, e.hd, e.pg, next_x, next_y, next_heading, next_progress);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending = next_state_q.size();

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for bicycle_model_euler_step_core: drives reset, the APB
// registers and corner-case and random state items. Depends on bme_pkg, the core and bme_step_checker.
`timescale 1ns / 100ps
module tb_top;
  import bme_pkg::*;

  localparam int LATENCY = 49;
  localparam longint CYCLE_LIMIT = 1500000;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic signed [31:0] pos_x = 0, pos_y = 0, heading = 0, progress = 0;
  logic [16:0] speed = 0, path_speed = 0;
  logic signed [17:0] steer_angle = 0;
  logic signed [31:0] next_x, next_y, next_heading, next_progress;
  logic [30:0] wheelbase_cfg = WHEELBASE_RESET;
  logic [16:0] time_step_cfg = TIME_STEP_RESET;
  int fail_count, pending, checked, sent = 0, send_idle = 0, stall_pct = 0;
  longint cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  bicycle_model_euler_step_core dut (.*);

  bme_step_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; paddr <= 3'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (idx == REG_WHEELBASE) wheelbase_cfg = val[30:0];
    else time_step_cfg = val[16:0];
  endtask

  // Stop sending and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Present one transaction and hold it until accepted.
  task automatic send_state(logic [31:0] x, y, h, p, logic [16:0] sp,
                            logic [17:0] st, logic [16:0] ps);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; pos_x <= x; pos_y <= y; heading <= h; progress <= p;
    speed <= sp; steer_angle <= st; path_speed <= ps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic random_state();
    logic [31:0] h;
    logic [17:0] st;
    logic [16:0] sp, ps;
    case ($urandom_range(3))
      0: h = $urandom;
      1: h = $urandom_range(0, 823550) - 411775;
      default: h = $signed($urandom_range(0, 13107)) - 6553;
    endcase
    st = ($urandom_range(9) == 0) ? 18'($urandom) : 18'($urandom_range(0, 131072) - 65536);
    sp = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    ps = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
    if ($urandom_range(7) == 0)
      send_state($urandom_range(1) ? 32'h7fffff00 : 32'h80000100, $urandom, h,
                 $urandom_range(1) ? 32'h7fffffff : 32'h80000000, sp, st, ps);
    else
      send_state($urandom, $urandom, h, $urandom, sp, st, ps);
  endtask

  initial begin
    logic [31:0] wb_set[4];
    logic [31:0] ts_set[4];
    wb_set = '{32'd655, 32'd0, 32'h7fffffff, 32'd98304};
    ts_set = '{32'd1, 32'd65536, 32'd131071, 32'd0};
    repeat (2) @(negedge clk);
    rst <= 0;
    // Corner cases at reset settings.
    send_state(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 17'd65536, 18'sd65536, 17'd65536);
    send_state(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 17'd65536,
               -18'sd65536, 17'd0);
    send_state(0, 0, 32'h7fffffff, 0, 17'h1ffff, 18'h1ffff, 17'h1ffff);
    send_state(0, 0, 32'sd102944, 0, 17'd65536, 18'h20000, 17'd1);
    send_state(0, 0, -32'sd102944, 0, 17'd0, 18'sd0, 17'd0);
    send_state(0, 0, 32'sd205887, 0, 17'd65536, 18'sd1, 17'd65536);
    send_state(0, 0, 32'sd411775, 0, 17'd65536, -18'sd1, 17'd65536);
    send_state(0, 0, 32'sd51472, 0, 17'd65536, 18'sd32768, 17'd65536);
    send_state(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 17'h15555,
               18'h2aaaa, 17'h0aaaa);
    for (int phase = 0; phase < 8; phase++) begin
      drain();
      if (phase < 4) write_reg(REG_WHEELBASE, wb_set[phase]);
      if (phase < 4) write_reg(REG_TIME_STEP, ts_set[phase]);
      else begin
        write_reg(REG_WHEELBASE, 32'd655 + $urandom_range(0, 200000));
        write_reg(REG_TIME_STEP, $urandom_range(1, 65536));
      end
      case (phase % 4)
        0: begin send_idle = 0; stall_pct = 0; end
        1: begin send_idle = 79; stall_pct = 0; end
        2: begin send_idle = 0; stall_pct = 79; end
        default: begin send_idle = 9; stall_pct = 9; end
      endcase
      for (int i = 0; i < 150; i++) random_state();
    end
    drain();
    $display("Covered %0d transactions over eight register settings and four idle patterns.",
             sent);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
